/* hw/rtl/pds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  localparam int MAX_JOBS    = 16;
  localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int ARR_W       = 16;
  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int TIME_W      = 21;
  localparam int JOB_INDEX_W = 4;

  localparam logic [ARR_W-1:0] ARR_NONE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic jump;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic last_result;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/pds_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pds_ctrl
  import pds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic last_job,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && last_job) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (!sts.found) begin
          state_next = ST_SCAN;
        end else if (sts.out_free) begin
          state_next = sts.last_result ? ST_IDLE : ST_SCAN;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_clear = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DECIDE: begin
        priority if (!sts.found) begin
          // nothing ready: jump to the next arrival and rescan
          cmd.jump       = 1'b1;
          cmd.scan_clear = 1'b1;
        end else if (sts.out_free) begin
          cmd.commit     = 1'b1;
          cmd.scan_clear = 1'b1;
        end else begin
          // result register still full
          cmd.commit     = 1'b0;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/pds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pds_datapath
  import pds_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [ARR_W-1:0]       arrival,
  input  wire logic [BURST_W-1:0]     burst,
  input  wire logic [PRIO_W-1:0]      prio,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [JOB_INDEX_W-1:0]      job_index,
  output logic [TIME_W-1:0]           start_tick,
  output logic [TIME_W-1:0]           finish_time,
  output logic [TIME_W-1:0]           turnaround,
  output logic [TIME_W-1:0]           waiting,
  output logic [TIME_W-1:0]           response,
  output logic [TIME_W-1:0]           idle_total,
  output logic [TIME_W-1:0]           cycle_length,
  output logic                        final_res
);

  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];

  logic [MAX_JOBS-1:0] done;
  logic [CNT_W-1:0]    job_count;
  logic [CNT_W-1:0]    res_cnt;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   prev_finish;
  logic [TIME_W-1:0]   idle_sum;
  logic [TIME_W-1:0]   latest_finish;
  logic                first_pending;
  logic [ARR_W-1:0]    earliest;

  logic [IDX_W-1:0]    k;
  logic                found;
  logic [IDX_W-1:0]    best_idx;
  logic [ARR_W-1:0]    best_arr;
  logic [BURST_W-1:0]  best_burst;
  logic [PRIO_W-1:0]   best_prio;
  logic [ARR_W-1:0]    min_arr;

  logic [ARR_W-1:0]    k_arr;
  logic [BURST_W-1:0]  k_burst;
  logic [PRIO_W-1:0]   k_prio;
  logic                ent_live;
  logic                ent_ready;
  logic                better;
  logic                has_room;

  logic [TIME_W-1:0]   fin;
  logic [TIME_W-1:0]   resp;
  logic [TIME_W-1:0]   turn;
  logic [TIME_W-1:0]   idle_next;
  logic [TIME_W-1:0]   latest_next;
  logic [TIME_W-1:0]   cyc;

  assign k_arr   = arr_mem[k];
  assign k_burst = burst_mem[k];
  assign k_prio  = prio_mem[k];

  assign ent_live  = !done[k];
  assign ent_ready = ent_live && (TIME_W'(k_arr) <= now);
  assign better    = !found || (k_prio > best_prio) ||
                     ((k_prio == best_prio) && (k_arr < best_arr));
  assign has_room  = job_count < CNT_W'(MAX_JOBS);

  assign fin         = now + TIME_W'(best_burst);
  assign resp        = now - TIME_W'(best_arr);
  assign turn        = fin - TIME_W'(best_arr);
  assign idle_next   = first_pending ? idle_sum : idle_sum + now - prev_finish;
  assign latest_next = (fin > latest_finish) ? fin : latest_finish;
  assign cyc         = latest_next - TIME_W'(earliest);

  assign sts.scan_last   = (CNT_W'(k) == job_count - CNT_W'(1));
  assign sts.found       = found;
  assign sts.last_result = (res_cnt == job_count - CNT_W'(1));
  assign sts.out_free    = !out_valid || out_ready;

  // job stores and result payload
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      arr_mem[job_count[IDX_W-1:0]]   <= arrival;
      burst_mem[job_count[IDX_W-1:0]] <= burst;
      prio_mem[job_count[IDX_W-1:0]]  <= prio;
    end
    if (cmd.scan_step && ent_ready && better) begin
      best_idx   <= k;
      best_arr   <= k_arr;
      best_burst <= k_burst;
      best_prio  <= k_prio;
    end
    if (cmd.commit) begin
      job_index    <= JOB_INDEX_W'(best_idx);
      start_tick   <= now;
      finish_time  <= fin;
      turnaround   <= turn;
      waiting      <= resp;
      response     <= resp;
      idle_total   <= sts.last_result ? idle_next : '0;
      cycle_length <= sts.last_result ? cyc : '0;
      final_res    <= sts.last_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= '0;
      job_count     <= '0;
      res_cnt       <= '0;
      now           <= '0;
      prev_finish   <= '0;
      idle_sum      <= '0;
      latest_finish <= '0;
      first_pending <= 1'b1;
      earliest      <= ARR_NONE;
      k             <= '0;
      found         <= 1'b0;
      min_arr       <= ARR_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load && has_room) begin
        job_count <= job_count + CNT_W'(1);
        if (arrival < earliest) earliest <= arrival;
      end

      if (cmd.scan_step) begin
        k <= k + IDX_W'(1);
        if (ent_ready && better) found <= 1'b1;
        if (ent_live && (k_arr < min_arr)) min_arr <= k_arr;
      end

      if (cmd.jump) begin
        now <= TIME_W'(min_arr);
      end

      if (cmd.commit) begin
        if (sts.last_result) begin
          // batch complete, back to empty
          done          <= '0;
          job_count     <= '0;
          res_cnt       <= '0;
          now           <= '0;
          prev_finish   <= '0;
          idle_sum      <= '0;
          latest_finish <= '0;
          first_pending <= 1'b1;
          earliest      <= ARR_NONE;
        end else begin
          done[best_idx] <= 1'b1;
          now            <= fin;
          prev_finish    <= fin;
          idle_sum       <= idle_next;
          first_pending  <= 1'b0;
          latest_finish  <= latest_next;
          res_cnt        <= res_cnt + CNT_W'(1);
        end
      end

      if (cmd.scan_clear) begin
        k       <= '0;
        found   <= 1'b0;
        min_arr <= ARR_NONE;
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/priority_dispatch_scheduler_core.sv */
// Non-preemptive priority dispatcher. Jobs are loaded one item per cycle; the
// item with last_job set closes the batch (jobs past MAX_JOBS are dropped) and
// the block then emits one result per stored job in dispatch order, with
// final_res, idle_total and cycle_length set on the last one. Each result
// takes a scan that reads one stored entry per cycle, then a commit; when no
// job has arrived yet, a second scan follows the jump to the next arrival.
// No new job is taken until the last result of the batch has been produced;
// results wait in an output register while the next dispatch is scanned.
`timescale 1ns / 1ps
`default_nettype none

module priority_dispatch_scheduler_core
  import pds_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ARR_W-1:0]       arrival,
  input  wire logic [BURST_W-1:0]     burst,
  input  wire logic [PRIO_W-1:0]      prio,
  input  wire logic                   last_job,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [JOB_INDEX_W-1:0]      job_index,
  output logic [TIME_W-1:0]           start_tick,
  output logic [TIME_W-1:0]           finish_time,
  output logic [TIME_W-1:0]           turnaround,
  output logic [TIME_W-1:0]           waiting,
  output logic [TIME_W-1:0]           response,
  output logic [TIME_W-1:0]           idle_total,
  output logic [TIME_W-1:0]           cycle_length,
  output logic                        final_res
);

  cmd_t cmd;
  sts_t sts;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_job (last_job),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pds_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .arrival      (arrival),
    .burst        (burst),
    .prio         (prio),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .job_index    (job_index),
    .start_tick   (start_tick),
    .finish_time  (finish_time),
    .turnaround   (turnaround),
    .waiting      (waiting),
    .response     (response),
    .idle_total   (idle_total),
    .cycle_length (cycle_length),
    .final_res    (final_res)
  );

endmodule

`default_nettype wire

/* hw/rtl/pds_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pds_checker
  import pds_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [JOB_INDEX_W-1:0] job_index,
  input wire logic [TIME_W-1:0]      start_tick,
  input wire logic [TIME_W-1:0]      finish_time,
  input wire logic [TIME_W-1:0]      turnaround,
  input wire logic [TIME_W-1:0]      waiting,
  input wire logic [TIME_W-1:0]      response,
  input wire logic [TIME_W-1:0]      idle_total,
  input wire logic [TIME_W-1:0]      cycle_length,
  input wire logic                   final_res
);

  // a pending item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(job_index) &&
      $stable(start_tick) && $stable(finish_time))
    else $error("result item changed while stalled");

  a_wait_eq_resp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> waiting == response)
    else $error("waiting differs from response");

  a_turn_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> TIME_W'(turnaround - response) == TIME_W'(finish_time - start_tick))
    else $error("turnaround inconsistent with start and finish");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_res |-> idle_total == '0 && cycle_length == '0)
    else $error("summary fields set on a non-final item");

  // no job is taken while a batch is being dispatched
  a_no_load_mid_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_res |-> !in_ready)
    else $error("input accepted during dispatch");

endmodule

bind priority_dispatch_scheduler_core pds_checker u_pds_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .job_index    (job_index),
  .start_tick   (start_tick),
  .finish_time  (finish_time),
  .turnaround   (turnaround),
  .waiting      (waiting),
  .response     (response),
  .idle_total   (idle_total),
  .cycle_length (cycle_length),
  .final_res    (final_res)
);

`default_nettype wire

/* tb/tb_priority_dispatch_scheduler_core.sv */
`timescale 1ns / 1ps

module tb_priority_dispatch_scheduler_core;
  import pds_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_JOBS = 435;

  typedef struct {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] bur;
    logic [PRIO_W-1:0]  pri;
    logic               last;
  } job_t;

  typedef struct {
    logic [JOB_INDEX_W-1:0] job_idx;
    logic [TIME_W-1:0]      t_start;
    logic [TIME_W-1:0]      t_finish;
    logic [TIME_W-1:0]      t_turn;
    logic [TIME_W-1:0]      t_wait;
    logic [TIME_W-1:0]      t_resp;
    logic [TIME_W-1:0]      t_idle;
    logic [TIME_W-1:0]      t_cycle;
    logic                   is_final;
  } dispatch_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ARR_W-1:0]       arrival = '0;
  logic [BURST_W-1:0]     burst = '0;
  logic [PRIO_W-1:0]      prio = '0;
  logic                   last_job = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [JOB_INDEX_W-1:0] job_index;
  logic [TIME_W-1:0]      start_tick;
  logic [TIME_W-1:0]      finish_time;
  logic [TIME_W-1:0]      turnaround;
  logic [TIME_W-1:0]      waiting;
  logic [TIME_W-1:0]      response;
  logic [TIME_W-1:0]      idle_total;
  logic [TIME_W-1:0]      cycle_length;
  logic                   final_res;

  priority_dispatch_scheduler_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrival      (arrival),
    .burst        (burst),
    .prio         (prio),
    .last_job     (last_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .job_index    (job_index),
    .start_tick   (start_tick),
    .finish_time  (finish_time),
    .turnaround   (turnaround),
    .waiting      (waiting),
    .response     (response),
    .idle_total   (idle_total),
    .cycle_length (cycle_length),
    .final_res    (final_res)
  );

  // scheduler shadow state
  logic [ARR_W-1:0]   arr_mem [MAX_JOBS];
  logic [BURST_W-1:0] bur_mem [MAX_JOBS];
  logic [PRIO_W-1:0]  pri_mem [MAX_JOBS];
  bit                 done_mem [MAX_JOBS];
  int                 n_stored;
  logic [TIME_W-1:0]  now_t;
  logic [TIME_W-1:0]  last_end;
  logic [TIME_W-1:0]  idle_acc;
  bit                 first_run;
  logic [ARR_W-1:0]   min_arr;
  logic [TIME_W-1:0]  max_end;

  job_t      job_feed[$];
  dispatch_t dispatch_due[$];
  job_t      nxt_job;

  int  cycles = 0;
  int  feed_gap = 0;
  int  sink_stall = 0;
  bit  feed_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  phase_cnt = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  jobs_taken = 0;
  int  jobs_dropped = 0;
  int  batches_done = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_sched();
    for (int k = 0; k < MAX_JOBS; k++) begin
      done_mem[k] = 1'b0;
    end
    n_stored  = 0;
    now_t     = '0;
    last_end  = '0;
    idle_acc  = '0;
    first_run = 1'b1;
    min_arr   = ARR_NONE;
    max_end   = '0;
  endfunction

  function automatic int best_ready();
    int best;
    best = -1;
    for (int k = 0; k < n_stored; k++) begin
      if (!done_mem[k] && TIME_W'(arr_mem[k]) <= now_t) begin
        if (best < 0 || pri_mem[k] > pri_mem[best] ||
            (pri_mem[k] == pri_mem[best] && arr_mem[k] < arr_mem[best])) begin
          best = k;
        end
      end
    end
    return best;
  endfunction

  task automatic take_job(input logic [ARR_W-1:0] a, input logic [BURST_W-1:0] b,
                          input logic [PRIO_W-1:0] p, input logic last);
    int best;
    int n;
    logic [ARR_W-1:0]  low;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] a_t;
    logic [TIME_W-1:0] b_t;
    dispatch_t res;
    jobs_taken++;
    if (n_stored < MAX_JOBS) begin
      arr_mem[n_stored]  = a;
      bur_mem[n_stored]  = b;
      pri_mem[n_stored]  = p;
      done_mem[n_stored] = 1'b0;
      n_stored++;
      if (a < min_arr) min_arr = a;
    end else begin
      jobs_dropped++;
    end
    if (last) begin
      n = n_stored;
      batches_done++;
      for (int r = 0; r < n; r++) begin
        best = best_ready();
        if (best < 0) begin
          // nothing arrived yet, jump to the next arrival
          low = ARR_NONE;
          for (int k = 0; k < n_stored; k++) begin
            if (!done_mem[k] && arr_mem[k] < low) low = arr_mem[k];
          end
          now_t = TIME_W'(low);
          best = best_ready();
          if (best < 0) best = 0;
        end
        a_t = TIME_W'(arr_mem[best]);
        b_t = TIME_W'(bur_mem[best]);
        st  = now_t;
        fin = st + b_t;
        if (!first_run) idle_acc = idle_acc + st - last_end;
        first_run = 1'b0;
        done_mem[best] = 1'b1;
        now_t    = fin;
        last_end = fin;
        if (fin > max_end) max_end = fin;
        res.job_idx  = JOB_INDEX_W'(best);
        res.t_start  = st;
        res.t_finish = fin;
        res.t_turn   = fin - a_t;
        res.t_wait   = fin - a_t - b_t;
        res.t_resp   = st - a_t;
        res.t_idle   = '0;
        res.t_cycle  = '0;
        res.is_final = 1'b0;
        if (r + 1 == n) begin
          res.t_idle   = idle_acc;
          res.t_cycle  = max_end - TIME_W'(min_arr);
          res.is_final = 1'b1;
        end
        dispatch_due.push_back(res);
      end
      clear_sched();
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
      end
    end
  endtask

  task automatic queue_job(input logic [ARR_W-1:0] a, input logic [BURST_W-1:0] b,
                           input logic [PRIO_W-1:0] p, input logic last);
    job_t j;
    j.arr  = a;
    j.bur  = b;
    j.pri  = p;
    j.last = last;
    job_feed.push_back(j);
  endtask

  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (phase_cnt % 128 == 0) begin
      feed_calm <= ($urandom_range(0, 3) == 0);
      sink_calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_job(arrival, burst, prio, last_job);
      end
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          feed_gap <= feed_gap - 1;
          in_valid <= 1'b0;
        end else if (job_feed.size() > 0) begin
          nxt_job = job_feed.pop_front();
          arrival  <= nxt_job.arr;
          burst    <= nxt_job.bur;
          prio     <= nxt_job.pri;
          last_job <= nxt_job.last;
          in_valid <= 1'b1;
          feed_gap <= pick_gap(feed_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (dispatch_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: unexpected, job_index %0d start %0d",
                     results_seen, job_index, start_tick);
          end
        end else begin
          check_field("job_index", TIME_W'(dispatch_due[0].job_idx), TIME_W'(job_index));
          check_field("start_tick", dispatch_due[0].t_start, start_tick);
          check_field("finish_time", dispatch_due[0].t_finish, finish_time);
          check_field("turnaround", dispatch_due[0].t_turn, turnaround);
          check_field("waiting", dispatch_due[0].t_wait, waiting);
          check_field("response", dispatch_due[0].t_resp, response);
          check_field("idle_total", dispatch_due[0].t_idle, idle_total);
          check_field("cycle_length", dispatch_due[0].t_cycle, cycle_length);
          check_field("final_res", TIME_W'(dispatch_due[0].is_final), TIME_W'(final_res));
          void'(dispatch_due.pop_front());
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        sink_stall <= pick_gap(sink_calm);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no completion after %0d cycles, %0d results still due",
             cycles, dispatch_due.size());
    $display("[priority_dispatch_scheduler_core] ERROR");
    $finish;
  end

  initial begin
    int n;
    int planned;
    int amode;
    int bmode;
    int pmode;
    logic [ARR_W-1:0]   a;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;
    clear_sched();

    // single jobs at the field extremes
    queue_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_job(16'h0000, 16'h0000, 8'h00, 1'b1);
    // idle start, equal prio and arrival tie, idle gap later
    queue_job(16'd500, 16'd10, 8'd4, 1'b0);
    queue_job(16'd100, 16'd20, 8'd4, 1'b0);
    queue_job(16'd100, 16'd5, 8'd4, 1'b1);
    // full batch plus two jobs past capacity, ties and late high prio
    for (int k = 0; k < MAX_JOBS + 2; k++) begin
      queue_job(ARR_W'((k % 4) * 3), (k == 5) ? 16'hFFFF : BURST_W'(k),
                (k == 9) ? 8'hFF : PRIO_W'(k % 3), k == MAX_JOBS + 1);
    end

    planned = 0;
    while (planned < RANDOM_JOBS) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        8:       n = MAX_JOBS;
        9:       n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
        default: n = $urandom_range(2, MAX_JOBS);
      endcase
      amode = $urandom_range(0, 2);
      bmode = $urandom_range(0, 2);
      pmode = $urandom_range(0, 1);
      for (int k = 0; k < n; k++) begin
        case (amode)
          0:       a = ARR_W'($urandom_range(0, 65535));
          1:       a = ARR_W'($urandom_range(0, 63));
          default: a = ARR_NONE - ARR_W'($urandom_range(0, 63));
        endcase
        case (bmode)
          0:       b = BURST_W'($urandom_range(0, 65535));
          1:       b = BURST_W'($urandom_range(0, 31));
          default: b = BURST_W'($urandom_range(0, 3));
        endcase
        p = pmode ? PRIO_W'($urandom_range(0, 255)) : PRIO_W'($urandom_range(0, 3));
        queue_job(a, b, p, k == n - 1);
      end
      planned += n;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (job_feed.size() != 0 || in_valid);
    while (dispatch_due.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);

    $display("%0d jobs in %0d batches, %0d beyond capacity dropped",
             jobs_taken, batches_done, jobs_dropped);
    $display("%0d dispatch results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[priority_dispatch_scheduler_core] OK");
    end else begin
      $display("[priority_dispatch_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pds_pkg.sv
hw/rtl/pds_ctrl.sv
hw/rtl/pds_datapath.sv
hw/rtl/priority_dispatch_scheduler_core.sv
hw/rtl/pds_checker.sv
tb/tb_priority_dispatch_scheduler_core.sv
